[hdl/adsc_pkg.sv]
package adsc_pkg;

	// special characters of the address syntax
	localparam logic [7:0] CH_ESC    = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LANGLE = 8'h3C;
	localparam logic [7:0] CH_RANGLE = 8'h3E;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam int unsigned POS_W = 12;
	localparam logic [POS_W-1:0] POS_MAX = 12'hFFF;

	// result codes
	typedef enum logic [2:0] {
		ST_DELIM       = 3'd0,
		ST_END         = 3'd1,
		ST_QUOTE       = 3'd2,
		ST_OPEN_PAREN  = 3'd3,
		ST_CLOSE_PAREN = 3'd4,
		ST_OPEN_ANGLE  = 3'd5,
		ST_CLOSE_ANGLE = 3'd6,
		ST_OVERFLOW    = 3'd7
	} status_t;

	// character classes found by the front end
	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_ESC,
		CLS_QUOTE,
		CLS_LPAREN,
		CLS_RPAREN,
		CLS_LANGLE,
		CLS_RANGLE
	} char_cls_t;

	// one classified beat between front and back
	typedef struct packed {
		logic      eos;
		logic      is_delim;
		char_cls_t cls;
	} item_t;

	// back end activity, for checks at the top level
	typedef struct packed {
		logic pop;
		logic emit;
	} back_obs_t;

endpackage

[hdl/adsc_if.sv]
interface adsc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;
	logic       end_of_string;

	modport source (output valid, char_byte, end_of_string, input ready);
	modport sink (input valid, char_byte, end_of_string, output ready);
endinterface

interface adsc_out_if;
	import adsc_pkg::*;
	logic       valid;
	logic       ready;
	logic [11:0] position;
	status_t    status;

	modport source (output valid, position, status, input ready);
	modport sink (input valid, position, status, output ready);
endinterface

interface adsc_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] delimiter_char;

	modport source (output valid, delimiter_char, input ready);
	modport sink (input valid, delimiter_char, output ready);
endinterface

[hdl/address_delimiter_scanner_top.sv]
// path: front stage register, then queue entry, then result register
// throughput: one character per cycle, sustained while results are taken;
//   characters that give no result keep flowing while a result waits
// the front stage, a two-entry queue and the scan state update are registered
// reset: asynchronous, clears scan state and queue, delimiter returns to ','
module address_delimiter_scanner_top #(
	parameter int unsigned MAX_DEPTH = 255,
	parameter int unsigned MAX_LEN   = 4095
) (
	input logic         clk,
	input logic         arst_n,
	adsc_in_if.sink     chars,
	adsc_cfg_if.sink    cfg,
	adsc_out_if.source  results
);
	import adsc_pkg::*;

	logic      f_valid, f_ready;
	item_t     f_data;
	logic      b_valid, b_ready;
	item_t     b_data;
	back_obs_t obs;

	// classify and stage
	adsc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars),
		.cfg     (cfg),
		.q_valid (f_valid),
		.q_ready (f_ready),
		.q_data  (f_data)
	);

	// decoupling queue
	adsc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  (f_data),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_data)
	);

	// scan state and result register
	adsc_back #(
		.MAX_DEPTH (MAX_DEPTH),
		.MAX_LEN   (MAX_LEN)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (b_valid),
		.q_ready (b_ready),
		.q_data  (b_data),
		.results (results),
		.obs     (obs)
	);

	// a new result never overwrites one that was not taken
	assert property (@(posedge clk) disable iff (!arst_n)
		obs.emit |-> (!results.valid || results.ready))
		else $error("result register overwritten");

	// the back end only consumes beats the queue holds
	assert property (@(posedge clk) disable iff (!arst_n)
		obs.pop |-> b_valid)
		else $error("pop from empty queue");

	// a full front stage with a full queue must stall the input
	assert property (@(posedge clk) disable iff (!arst_n)
		(f_valid && !f_ready) |-> !chars.ready)
		else $error("input taken while front stage blocked");

endmodule

[hdl/adsc_front.sv]
module adsc_front (
	input  logic            clk,
	input  logic            arst_n,
	adsc_in_if.sink         chars,
	adsc_cfg_if.sink        cfg,
	output logic            q_valid,
	input  logic            q_ready,
	output adsc_pkg::item_t q_data
);
	import adsc_pkg::*;

	logic [7:0] delim_q;
	logic       valid_s1;
	item_t      item_s1;
	item_t      item_d;
	logic       take;

	// delimiter register, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= CH_COMMA;
		end else if (cfg.valid) begin
			delim_q <= cfg.delimiter_char;
		end
	end

	// classify the incoming character
	always_comb begin
		item_d.eos      = chars.end_of_string;
		item_d.is_delim = (chars.char_byte == delim_q);
		unique case (chars.char_byte)
			CH_ESC:    item_d.cls = CLS_ESC;
			CH_QUOTE:  item_d.cls = CLS_QUOTE;
			CH_LPAREN: item_d.cls = CLS_LPAREN;
			CH_RPAREN: item_d.cls = CLS_RPAREN;
			CH_LANGLE: item_d.cls = CLS_LANGLE;
			CH_RANGLE: item_d.cls = CLS_RANGLE;
			default:   item_d.cls = CLS_OTHER;
		endcase
	end

	// stage register in front of the queue
	assign chars.ready = !valid_s1 || q_ready;
	assign take        = chars.valid && chars.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign q_valid = valid_s1;
	assign q_data  = item_s1;

endmodule

[hdl/adsc_queue.sv]
module adsc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_valid,
	output logic            wr_ready,
	input  adsc_pkg::item_t wr_data,
	output logic            rd_valid,
	input  logic            rd_ready,
	output adsc_pkg::item_t rd_data
);
	import adsc_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = ent_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

[hdl/adsc_back.sv]
module adsc_back #(
	parameter int unsigned MAX_DEPTH = 255,
	parameter int unsigned MAX_LEN   = 4095
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_ready,
	input  adsc_pkg::item_t   q_data,
	adsc_out_if.source        results,
	output adsc_pkg::back_obs_t obs
);
	import adsc_pkg::*;

	localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
	localparam int unsigned IW = $clog2(MAX_LEN + 1);
	localparam int unsigned PW = (IW > POS_W) ? IW : POS_W;

	// scan state
	logic          esc_q, quote_q, done_q;
	logic [DW-1:0] cdep_q, bdep_q;
	logic [IW-1:0] idx_q;
	logic          esc_n, quote_n, done_n;
	logic [DW-1:0] cdep_n, bdep_n;
	logic [IW-1:0] idx_n;

	// output register
	logic             ov_q;
	logic [POS_W-1:0] pos_q;
	status_t          st_q;

	logic             emit;
	status_t          st_d;
	logic [PW-1:0]    idx_ext;
	logic [POS_W-1:0] pos_d;
	logic             pop;

	// saturated position of the current character
	assign idx_ext = PW'(idx_q);
	assign pos_d   = (idx_ext > PW'(POS_MAX)) ? POS_MAX : idx_ext[POS_W-1:0];

	// state update for one beat
	always_comb begin
		esc_n   = esc_q;
		quote_n = quote_q;
		cdep_n  = cdep_q;
		bdep_n  = bdep_q;
		idx_n   = idx_q;
		done_n  = done_q;
		emit    = 1'b0;
		st_d    = ST_DELIM;
		if (q_data.eos) begin
			if (!done_q) begin
				emit = 1'b1;
				priority if (quote_q)      st_d = ST_QUOTE;
				else if (cdep_q != '0)     st_d = ST_OPEN_PAREN;
				else if (bdep_q != '0)     st_d = ST_OPEN_ANGLE;
				else                       st_d = ST_END;
			end
			esc_n   = 1'b0;
			quote_n = 1'b0;
			cdep_n  = '0;
			bdep_n  = '0;
			idx_n   = '0;
			done_n  = 1'b0;
		end else if (!done_q) begin
			priority if (esc_q) begin
				esc_n = 1'b0;
			end else if (q_data.cls == CLS_ESC) begin
				esc_n = 1'b1;
			end else if (q_data.cls == CLS_QUOTE) begin
				quote_n = !quote_q;
			end else if (quote_q) begin
				quote_n = 1'b1;
			end else if (q_data.is_delim && cdep_q == '0 && bdep_q == '0) begin
				emit = 1'b1;
				st_d = ST_DELIM;
			end else if (q_data.cls == CLS_LPAREN) begin
				if (cdep_q >= DW'(MAX_DEPTH)) begin
					emit = 1'b1;
					st_d = ST_OVERFLOW;
				end else begin
					cdep_n = cdep_q + DW'(1);
				end
			end else if (q_data.cls == CLS_RPAREN) begin
				if (cdep_q == '0) begin
					emit = 1'b1;
					st_d = ST_CLOSE_PAREN;
				end else begin
					cdep_n = cdep_q - DW'(1);
				end
			end else if (cdep_q != '0) begin
				cdep_n = cdep_q;
			end else if (q_data.cls == CLS_LANGLE) begin
				if (bdep_q >= DW'(MAX_DEPTH)) begin
					emit = 1'b1;
					st_d = ST_OVERFLOW;
				end else begin
					bdep_n = bdep_q + DW'(1);
				end
			end else if (q_data.cls == CLS_RANGLE) begin
				if (bdep_q == '0) begin
					emit = 1'b1;
					st_d = ST_CLOSE_ANGLE;
				end else begin
					bdep_n = bdep_q - DW'(1);
				end
			end else begin
				bdep_n = bdep_q;
			end
			if (emit) done_n = 1'b1;
			if (idx_q < IW'(MAX_LEN)) idx_n = idx_q + IW'(1);
		end
	end

	// a beat with no result never waits on the output
	assign pop     = q_valid && (!emit || !ov_q || results.ready);
	assign q_ready = !emit || !ov_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			quote_q <= 1'b0;
			cdep_q  <= '0;
			bdep_q  <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else if (pop) begin
			esc_q   <= esc_n;
			quote_q <= quote_n;
			cdep_q  <= cdep_n;
			bdep_q  <= bdep_n;
			idx_q   <= idx_n;
			done_q  <= done_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (pop && emit) begin
			ov_q <= 1'b1;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			pos_q <= pos_d;
			st_q  <= st_d;
		end
	end

	assign results.valid    = ov_q;
	assign results.position = pos_q;
	assign results.status   = st_q;

	assign obs.pop  = pop;
	assign obs.emit = pop && emit;

endmodule

[sim/address_delimiter_scanner_top_test.sv]
`timescale 1ns / 1ps

import adsc_pkg::*;

localparam int unsigned DEPTH_LIMIT = 255;
localparam int unsigned LEN_LIMIT   = 4095;

// one expected scan outcome
typedef struct packed {
	logic [POS_W-1:0] position;
	status_t          status;
} scan_report_t;

// tracks the scan state of the current string and the reports still owed
class delim_scan_board;
	logic [7:0]       delim;
	bit               esc_pend;
	bit               quoted;
	logic [7:0]       paren_depth;
	logic [7:0]       angle_depth;
	logic [POS_W-1:0] char_pos;
	bit               reported;
	scan_report_t     awaited_reports[$];
	int unsigned      mismatches;

	function new();
		delim = CH_COMMA;
		mismatches = 0;
		clear_scan();
	endfunction

	function void clear_scan();
		esc_pend = 1'b0;
		quoted = 1'b0;
		paren_depth = '0;
		angle_depth = '0;
		char_pos = '0;
		reported = 1'b0;
	endfunction

	function void set_delim(logic [7:0] d);
		delim = d;
	endfunction

	function void push_report(status_t st);
		scan_report_t rep;
		rep.position = char_pos;
		rep.status = st;
		awaited_reports.push_back(rep);
	endfunction

	// advance the scan by one accepted beat
	function void scan_char(logic [7:0] c, logic eos);
		status_t st;
		bit      hit;
		hit = 1'b0;
		st = ST_END;
		// end of string reports once, then always clears
		if (eos) begin
			if (!reported) begin
				if (quoted)
					st = ST_QUOTE;
				else if (paren_depth != 0)
					st = ST_OPEN_PAREN;
				else if (angle_depth != 0)
					st = ST_OPEN_ANGLE;
				else
					st = ST_END;
				push_report(st);
			end
			clear_scan();
			return;
		end
		// rest of string ignored after a report
		if (reported)
			return;
		if (esc_pend) begin
			esc_pend = 1'b0;
		end else if (c == CH_ESC) begin
			esc_pend = 1'b1;
		end else if (c == CH_QUOTE) begin
			quoted = !quoted;
		end else if (quoted) begin
			// quoted text
		end else if (c == delim && angle_depth == 0 && paren_depth == 0) begin
			st = ST_DELIM;
			hit = 1'b1;
		end else if (c == CH_LPAREN) begin
			if (paren_depth >= DEPTH_LIMIT) begin
				st = ST_OVERFLOW;
				hit = 1'b1;
			end else begin
				paren_depth = paren_depth + 1'b1;
			end
		end else if (c == CH_RPAREN) begin
			if (paren_depth == 0) begin
				st = ST_CLOSE_PAREN;
				hit = 1'b1;
			end else begin
				paren_depth = paren_depth - 1'b1;
			end
		end else if (paren_depth != 0) begin
			// comment text
		end else if (c == CH_LANGLE) begin
			if (angle_depth >= DEPTH_LIMIT) begin
				st = ST_OVERFLOW;
				hit = 1'b1;
			end else begin
				angle_depth = angle_depth + 1'b1;
			end
		end else if (c == CH_RANGLE) begin
			if (angle_depth == 0) begin
				st = ST_CLOSE_ANGLE;
				hit = 1'b1;
			end else begin
				angle_depth = angle_depth - 1'b1;
			end
		end
		if (hit) begin
			push_report(st);
			reported = 1'b1;
		end
		if (char_pos < LEN_LIMIT)
			char_pos = char_pos + 1'b1;
	endfunction

	// compare one accepted result beat with the oldest owed report
	function void match_report(logic [POS_W-1:0] pos, status_t st);
		scan_report_t want;
		if (awaited_reports.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: position %0d status %0d", pos, st);
			return;
		end
		want = awaited_reports.pop_front();
		if (want.position !== pos || want.status !== st) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected pos %0d st %0d, got pos %0d st %0d",
					want.position, want.status, pos, st);
		end
	endfunction
endclass

module address_delimiter_scanner_top_test;

	localparam int unsigned GAP_PCT     = 7;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned STALL_LIMIT = 3000;
	localparam int unsigned SETTLE      = 10;

	logic clk = 1'b0;
	logic arst_n;

	adsc_in_if  chars_bus ();
	adsc_cfg_if cfg_bus ();
	adsc_out_if results_bus ();

	address_delimiter_scanner_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_bus),
		.cfg     (cfg_bus),
		.results (results_bus)
	);

	delim_scan_board board;
	bit              quiet;
	bit              hold_request;
	int unsigned     items_sent;
	int unsigned     stall_count;
	logic [7:0]      addr_text[$];

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predict on every accepted character beat
	always @(posedge clk) begin
		if (chars_bus.valid && chars_bus.ready)
			board.scan_char(chars_bus.char_byte, chars_bus.end_of_string);
	end

	// check every accepted result beat
	always @(posedge clk) begin
		if (results_bus.valid && results_bus.ready)
			board.match_report(results_bus.position, results_bus.status);
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (chars_bus.valid && chars_bus.ready)
				|| (results_bus.valid && results_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
			stall_count <= 0;
		end else if (stall_count >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			stall_count <= stall_count + 1;
		end
	end

	// result receiver with random stalls and an occasional long hold-off
	initial begin
		int unsigned held;
		results_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				results_bus.ready <= 1'b0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_request = 1'b0;
			end
			results_bus.ready <= quiet || ($urandom_range(99) >= GAP_PCT);
		end
	end

	// offer one character beat, called at a falling edge
	task automatic send_char(input logic [7:0] c, input logic eos);
		while (!quiet && $urandom_range(99) < GAP_PCT) begin
			chars_bus.valid <= 1'b0;
			@(negedge clk);
		end
		chars_bus.valid <= 1'b1;
		chars_bus.char_byte <= c;
		chars_bus.end_of_string <= eos;
		do
			@(posedge clk);
		while (!chars_bus.ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_string(input string s);
		int k;
		for (k = 0; k < s.len(); k++)
			send_char(s[k], 1'b0);
		send_char(8'h00, 1'b1);
	endtask

	// let every owed report arrive, then let in-flight beats settle
	task automatic drain_scanner();
		chars_bus.valid <= 1'b0;
		@(negedge clk);
		while (board.awaited_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_delim(input logic [7:0] d);
		cfg_bus.valid <= 1'b1;
		cfg_bus.delimiter_char <= d;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		board.set_delim(d);
		@(negedge clk);
		cfg_bus.valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char(logic [7:0] d);
		int unsigned r;
		r = $urandom_range(99);
		if (r < 40)
			return 8'h61 + 8'($urandom_range(25));
		else if (r < 50)
			return d;
		else if (r < 56)
			return CH_LPAREN;
		else if (r < 62)
			return CH_RPAREN;
		else if (r < 68)
			return CH_LANGLE;
		else if (r < 74)
			return CH_RANGLE;
		else if (r < 80)
			return CH_QUOTE;
		else if (r < 86)
			return CH_ESC;
		else
			return 8'($urandom_range(255));
	endfunction

	// build one address; balanced ones close every quote, comment and bracket
	function automatic void build_address(bit balanced, logic [7:0] d);
		logic [7:0]  closers[$];
		int unsigned n;
		int unsigned k;
		int unsigned tail;
		logic [7:0]  c;
		bit          in_q;
		addr_text.delete();
		in_q = 1'b0;
		n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(14);
		for (k = 0; k < n; k++) begin
			c = pick_char(d);
			if (balanced) begin
				if (c == CH_ESC) begin
					addr_text.push_back(c);
					c = 8'h61 + 8'($urandom_range(25));
				end else if (c == CH_QUOTE) begin
					in_q = !in_q;
				end else if (!in_q) begin
					if (c == CH_LPAREN)
						closers.push_back(CH_RPAREN);
					else if (c == CH_LANGLE)
						closers.push_back(CH_RANGLE);
					else if (c == CH_RPAREN || c == CH_RANGLE) begin
						if (closers.size() != 0 && closers[$] == c)
							void'(closers.pop_back());
						else
							c = 8'h78;
					end
				end
			end
			addr_text.push_back(c);
		end
		if (balanced) begin
			if (in_q)
				addr_text.push_back(CH_QUOTE);
			while (closers.size() != 0)
				addr_text.push_back(closers.pop_back());
			if ($urandom_range(1)) begin
				addr_text.push_back(d);
				tail = $urandom_range(6);
				for (k = 0; k < tail; k++)
					addr_text.push_back(pick_char(d));
			end
		end
	endfunction

	task automatic random_strings(input int unsigned count);
		int unsigned stop;
		stop = items_sent + count;
		while (items_sent < stop) begin
			build_address($urandom_range(99) < 70, board.delim);
			foreach (addr_text[k])
				send_char(addr_text[k], 1'b0);
			send_char(8'($urandom_range(255)), 1'b1);
		end
	endtask

	// main sequence
	initial begin
		int k;
		board = new();
		quiet = 1'b0;
		hold_request = 1'b0;
		items_sent = 0;
		stall_count = 0;
		arst_n = 1'b0;
		chars_bus.valid = 1'b0;
		chars_bus.char_byte = 8'h00;
		chars_bus.end_of_string = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.delimiter_char = 8'h00;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed cases with the reset delimiter
		send_string(",");
		send_char(8'hFF, 1'b1);
		send_string("\\,");
		send_string("\",");
		send_string("(");
		send_char(CH_RPAREN, 1'b0);
		send_char(8'h00, 1'b1);
		send_string("<");
		send_string(">x");
		send_char(8'h00, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h00, 1'b1);
		send_string("<,>");

		// depth limits
		for (k = 0; k <= DEPTH_LIMIT; k++)
			send_char(CH_LPAREN, 1'b0);
		send_char(8'h00, 1'b1);
		for (k = 0; k <= DEPTH_LIMIT; k++)
			send_char(CH_LANGLE, 1'b0);
		send_char(8'h00, 1'b1);

		// random phases over several delimiter settings
		random_strings(150);
		drain_scanner();
		write_delim(8'h00);
		random_strings(80);
		drain_scanner();
		write_delim(8'hFF);
		random_strings(80);
		drain_scanner();
		write_delim(CH_QUOTE);
		random_strings(60);
		drain_scanner();
		write_delim(CH_LPAREN);
		random_strings(60);
		drain_scanner();
		write_delim(8'($urandom_range(255)));
		quiet = 1'b1;
		random_strings(120);
		quiet = 1'b0;

		// receiver holds off while short reporting strings pile up
		hold_request = 1'b1;
		for (k = 0; k < 40; k++) begin
			send_char(board.delim, 1'b0);
			send_char(8'h00, 1'b1);
		end
		drain_scanner();
		write_delim(CH_COMMA);
		random_strings(100);

		drain_scanner();
		if (board.mismatches == 0 && board.awaited_reports.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
